>>> hdl/stv_pkg.sv
// Shared widths and pipeline sideband types for the step toward target block.
package stv_pkg;

	localparam int FRAC_BITS = 16;
	localparam int COORD_W   = 32;
	localparam int DIFF_W    = COORD_W + 1;
	localparam int SPEED_W   = 31;
	localparam int EPS_W     = 16;
	localparam int SQ_W      = 2 * DIFF_W;
	localparam int SQ_IN_W   = SQ_W + 2;
	localparam int ROOT_W    = SQ_IN_W / 2;
	localparam int SREM_W    = ROOT_W + 3;
	localparam int NUM_W     = DIFF_W + SPEED_W;
	localparam int Q_W       = SPEED_W;
	localparam int DREM_W    = ROOT_W;
	localparam int THR_W     = EPS_W + FRAC_BITS + 1;
	localparam int PROD_W    = 2 * DIFF_W + 1;

	typedef struct packed {
		logic signed [DIFF_W-1:0] dx;
		logic signed [DIFF_W-1:0] dy;
		logic [NUM_W-1:0]         nx;
		logic [NUM_W-1:0]         ny;
	} sqrt_side_t;

	typedef struct packed {
		logic signed [DIFF_W-1:0] dx;
		logic signed [DIFF_W-1:0] dy;
		logic                     scale;
	} div_side_t;

	function automatic logic [DIFF_W-1:0] mag(input logic signed [DIFF_W-1:0] v);
		mag = v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
	endfunction

endpackage

>>> hdl/stv_sqrt.sv
// Pipelined integer square root, one root bit per stage, with sideband.
module stv_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [stv_pkg::SQ_IN_W-1:0]   in_sq,
	input  stv_pkg::sqrt_side_t           in_side,
	output logic                          out_valid,
	output logic [stv_pkg::ROOT_W-1:0]    out_root,
	output stv_pkg::sqrt_side_t           out_side
);
	localparam int N = stv_pkg::ROOT_W;

	logic                          valid_sn [0:N];
	logic [stv_pkg::SQ_IN_W-1:0]   sq_sn    [0:N];
	logic [stv_pkg::SREM_W-1:0]    rem_sn   [0:N];
	logic [stv_pkg::ROOT_W-1:0]    root_sn  [0:N];
	stv_pkg::sqrt_side_t           side_sn  [0:N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sn[0] <= 1'b0;
		end else if (en) begin
			valid_sn[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_sn[0]   <= in_sq;
			rem_sn[0]  <= '0;
			root_sn[0] <= '0;
			side_sn[0] <= in_side;
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [stv_pkg::SREM_W-1:0] rem_sh;
		logic [stv_pkg::SREM_W-1:0] trial;
		logic                       ge;

		always_comb begin
			rem_sh = {rem_sn[k][stv_pkg::SREM_W-3:0],
				sq_sn[k][stv_pkg::SQ_IN_W-1 -: 2]};
			trial  = stv_pkg::SREM_W'({root_sn[k], 2'b01});
			ge     = rem_sh >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_sn[k+1] <= 1'b0;
			end else if (en) begin
				valid_sn[k+1] <= valid_sn[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_sn[k+1]   <= {sq_sn[k][stv_pkg::SQ_IN_W-3:0], 2'b00};
				rem_sn[k+1]  <= ge ? rem_sh - trial : rem_sh;
				root_sn[k+1] <= {root_sn[k][stv_pkg::ROOT_W-2:0], ge};
				side_sn[k+1] <= side_sn[k];
			end
		end
	end

	assign out_valid = valid_sn[N];
	assign out_root  = root_sn[N];
	assign out_side  = side_sn[N];

endmodule

>>> hdl/stv_div.sv
// Pipelined restoring divider for both axes, one quotient bit per stage.
module stv_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [stv_pkg::NUM_W-1:0]     in_nx,
	input  logic [stv_pkg::NUM_W-1:0]     in_ny,
	input  logic [stv_pkg::ROOT_W-1:0]    in_len,
	input  stv_pkg::div_side_t            in_side,
	output logic                          out_valid,
	output logic [stv_pkg::Q_W-1:0]       out_qx,
	output logic [stv_pkg::Q_W-1:0]       out_qy,
	output stv_pkg::div_side_t            out_side
);
	localparam int N  = stv_pkg::Q_W;
	localparam int RW = stv_pkg::DREM_W;

	logic                        valid_sn [0:N];
	logic [RW-1:0]               remx_sn  [0:N];
	logic [RW-1:0]               remy_sn  [0:N];
	logic [N-1:0]                lowx_sn  [0:N];
	logic [N-1:0]                lowy_sn  [0:N];
	logic [N-1:0]                qx_sn    [0:N];
	logic [N-1:0]                qy_sn    [0:N];
	logic [stv_pkg::ROOT_W-1:0]  len_sn   [0:N];
	stv_pkg::div_side_t          side_sn  [0:N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sn[0] <= 1'b0;
		end else if (en) begin
			valid_sn[0] <= in_valid;
		end
	end

	// quotient fits Q_W bits, so the top part of the numerator is below len
	always_ff @(posedge clk) begin
		if (en) begin
			remx_sn[0] <= RW'(in_nx[stv_pkg::NUM_W-1:N]);
			remy_sn[0] <= RW'(in_ny[stv_pkg::NUM_W-1:N]);
			lowx_sn[0] <= in_nx[N-1:0];
			lowy_sn[0] <= in_ny[N-1:0];
			qx_sn[0]   <= '0;
			qy_sn[0]   <= '0;
			len_sn[0]  <= in_len;
			side_sn[0] <= in_side;
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [RW:0] shx, shy, dv;
		logic        gex, gey;

		always_comb begin
			shx = {remx_sn[k], lowx_sn[k][N-1]};
			shy = {remy_sn[k], lowy_sn[k][N-1]};
			dv  = (RW+1)'(len_sn[k]);
			gex = shx >= dv;
			gey = shy >= dv;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_sn[k+1] <= 1'b0;
			end else if (en) begin
				valid_sn[k+1] <= valid_sn[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				remx_sn[k+1] <= RW'(gex ? shx - dv : shx);
				remy_sn[k+1] <= RW'(gey ? shy - dv : shy);
				lowx_sn[k+1] <= {lowx_sn[k][N-2:0], 1'b0};
				lowy_sn[k+1] <= {lowy_sn[k][N-2:0], 1'b0};
				qx_sn[k+1]   <= {qx_sn[k][N-2:0], gex};
				qy_sn[k+1]   <= {qy_sn[k][N-2:0], gey};
				len_sn[k+1]  <= len_sn[k];
				side_sn[k+1] <= side_sn[k];
			end
		end
	end

	assign out_valid = valid_sn[N];
	assign out_qx    = qx_sn[N];
	assign out_qy    = qy_sn[N];
	assign out_side  = side_sn[N];

endmodule

>>> hdl/step_toward_target_velocity_top.sv
// Top level: difference, squares, root, scaling divide, overshoot test, saturation.
//
// Input transfer on s_axis: pos_x, pos_y, target_x, target_y, speed packed in
// s_axis_tdata. Each transfer produces exactly one result transfer on m_axis
// carrying step_x, step_y, in input order.
// Between input transfer and m_axis_tvalid lie three front stages, the
// square root input register and 34 root stages (one root bit each), the
// divider input register and 31 quotient stages (one quotient bit each), two
// overshoot stages and the output register.
// Throughput is one item per cycle while the output is not stalled; the
// bit-per-stage root and divide pipelines set the depth, not the rate.
// The whole pipeline advances together. When m_axis_tready is low while a
// result is held, every stage freezes and s_axis_tready drops; nothing is
// lost or repeated. Bubbles in flight are kept as invalid slots.
// Reset clears all valid bits and sets epsilon to 1. cfg_we writes epsilon
// from cfg_wdata; write it only when no item is in flight.
module step_toward_target_velocity_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [15:0]  cfg_wdata,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// pos_x[31:0], pos_y[63:32], target_x[95:64], target_y[127:96],
	// speed[158:128], zero[159]
	input  logic [159:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// step_x[31:0], step_y[63:32]
	output logic [63:0]  m_axis_tdata
);
	localparam int DW = stv_pkg::DIFF_W;
	localparam int CW = stv_pkg::COORD_W;

	logic [stv_pkg::EPS_W-1:0] eps_q;
	logic                      en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= stv_pkg::EPS_W'(1);
		end else if (cfg_we) begin
			eps_q <= cfg_wdata;
		end
	end

	assign en            = m_axis_tready || !m_axis_tvalid;
	assign s_axis_tready = en;

	// stage 1: differences
	logic                      valid_s1;
	logic signed [DW-1:0]      dx_s1, dy_s1;
	logic [stv_pkg::SPEED_W-1:0] speed_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= DW'($signed(s_axis_tdata[95:64])) - DW'($signed(s_axis_tdata[31:0]));
			dy_s1 <= DW'($signed(s_axis_tdata[127:96])) - DW'($signed(s_axis_tdata[63:32]));
			speed_s1 <= s_axis_tdata[158:128];
		end
	end

	// stage 2: products
	logic                         valid_s2;
	logic signed [DW-1:0]         dx_s2, dy_s2;
	logic [stv_pkg::SQ_W-1:0]     sqx_s2, sqy_s2;
	logic [stv_pkg::NUM_W-1:0]    nx_s2, ny_s2;
	logic [DW-1:0]                mx1, my1;

	assign mx1 = stv_pkg::mag(dx_s1);
	assign my1 = stv_pkg::mag(dy_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s2  <= dx_s1;
			dy_s2  <= dy_s1;
			sqx_s2 <= mx1 * mx1;
			sqy_s2 <= my1 * my1;
			nx_s2  <= mx1 * speed_s1;
			ny_s2  <= my1 * speed_s1;
		end
	end

	// stage 3: sum of squares
	logic                          valid_s3;
	logic [stv_pkg::SQ_IN_W-1:0]   sum_s3;
	stv_pkg::sqrt_side_t           side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3     <= stv_pkg::SQ_IN_W'(sqx_s2) + stv_pkg::SQ_IN_W'(sqy_s2);
			side_s3.dx <= dx_s2;
			side_s3.dy <= dy_s2;
			side_s3.nx <= nx_s2;
			side_s3.ny <= ny_s2;
		end
	end

	logic                        sq_valid;
	logic [stv_pkg::ROOT_W-1:0]  sq_root;
	stv_pkg::sqrt_side_t         sq_side;
	stv_pkg::div_side_t          dv_side_in;

	stv_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s3),
		.in_sq     (sum_s3),
		.in_side   (side_s3),
		.out_valid (sq_valid),
		.out_root  (sq_root),
		.out_side  (sq_side)
	);

	always_comb begin
		dv_side_in.dx    = sq_side.dx;
		dv_side_in.dy    = sq_side.dy;
		dv_side_in.scale = sq_root > stv_pkg::ROOT_W'(eps_q);
	end

	logic                     dv_valid;
	logic [stv_pkg::Q_W-1:0]  dv_qx, dv_qy;
	stv_pkg::div_side_t       dv_side;

	stv_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_valid),
		.in_nx     (sq_side.nx),
		.in_ny     (sq_side.ny),
		.in_len    (sq_root),
		.in_side   (dv_side_in),
		.out_valid (dv_valid),
		.out_qx    (dv_qx),
		.out_qy    (dv_qy),
		.out_side  (dv_side)
	);

	// stage 4: remaining distance after a scaled step, in magnitudes
	logic                     valid_s4;
	logic signed [DW-1:0]     dx_s4, dy_s4;
	logic [stv_pkg::Q_W-1:0]  qx_s4, qy_s4;
	logic                     scale_s4;
	logic [DW-1:0]            fx_s4, fy_s4;
	logic                     fposx_s4, fposy_s4;
	logic signed [DW+1:0]     fdx, fdy;

	assign fdx = $signed({2'b00, stv_pkg::mag(dv_side.dx)}) - $signed((DW+2)'(dv_qx));
	assign fdy = $signed({2'b00, stv_pkg::mag(dv_side.dy)}) - $signed((DW+2)'(dv_qy));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s4    <= dv_side.dx;
			dy_s4    <= dv_side.dy;
			qx_s4    <= dv_qx;
			qy_s4    <= dv_qy;
			scale_s4 <= dv_side.scale;
			fx_s4    <= fdx[DW-1:0];
			fy_s4    <= fdy[DW-1:0];
			fposx_s4 <= (fdx > 0) && (dv_side.dx != 0);
			fposy_s4 <= (fdy > 0) && (dv_side.dy != 0);
		end
	end

	// stage 5: overshoot products
	logic                        valid_s5;
	logic signed [DW-1:0]        dx_s5, dy_s5;
	logic [stv_pkg::Q_W-1:0]     qx_s5, qy_s5;
	logic                        scale_s5, fposx_s5, fposy_s5;
	logic [stv_pkg::PROD_W-1:0]  px_s5, py_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s5    <= dx_s4;
			dy_s5    <= dy_s4;
			qx_s5    <= qx_s4;
			qy_s5    <= qy_s4;
			scale_s5 <= scale_s4;
			fposx_s5 <= fposx_s4;
			fposy_s5 <= fposy_s4;
			px_s5    <= stv_pkg::PROD_W'(fx_s4) * stv_pkg::PROD_W'(stv_pkg::mag(dx_s4));
			py_s5    <= stv_pkg::PROD_W'(fy_s4) * stv_pkg::PROD_W'(stv_pkg::mag(dy_s4));
		end
	end

	// output stage: overshoot decision, sign restore, saturation
	logic [stv_pkg::THR_W-1:0] thresh;
	logic                      okx, oky, take_d;
	logic signed [DW-1:0]      vx, vy;
	logic [CW-1:0]             sx, sy;

	function automatic logic [CW-1:0] sat(input logic signed [DW-1:0] v);
		if (v[DW-1] != v[DW-2]) begin
			sat = v[DW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
		end else begin
			sat = v[CW-1:0];
		end
	endfunction

	always_comb begin
		thresh = ((stv_pkg::THR_W'(eps_q) + 1'b1) << stv_pkg::FRAC_BITS) - 1'b1;
		okx    = !fposx_s5 || (px_s5 <= stv_pkg::PROD_W'(thresh));
		oky    = !fposy_s5 || (py_s5 <= stv_pkg::PROD_W'(thresh));
		take_d = !scale_s5 || (okx && oky);
		vx     = dx_s5[DW-1] ? -$signed(DW'(qx_s5)) : $signed(DW'(qx_s5));
		vy     = dy_s5[DW-1] ? -$signed(DW'(qy_s5)) : $signed(DW'(qy_s5));
		sx     = sat(take_d ? dx_s5 : vx);
		sy     = sat(take_d ? dy_s5 : vy);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (en) begin
			m_axis_tvalid <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_axis_tdata <= {sy, sx};
		end
	end

`ifndef SYNTHESIS
	a_ready_follows_out: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (m_axis_tready || !m_axis_tvalid))
		else $error("input ready does not track output stall");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("result changed while stalled");

	a_stage_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> ($stable(valid_s1) && $stable(valid_s5)))
		else $error("pipeline moved during stall");
`endif

endmodule

>>> bench/step_toward_target_velocity_top_test.sv
// Self-checking testbench for the step toward target velocity block.
module step_toward_target_velocity_top_test;

	localparam int LIMIT = 400000;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [15:0]  cfg_wdata;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [159:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [63:0]  m_axis_tdata;

	step_toward_target_velocity_top i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
	);

	logic [159:0] pending_moves[$];
	logic [63:0]  expected_steps[$];
	logic [15:0]  epsilon;
	int           idle_pct, stall_pct;
	int           errors, cycles, hold_cnt;
	logic         in_xfer, hold_go, hold_done;

	function automatic logic [67:0] mag68(longint v);
		mag68 = v < 0 ? 68'(-v) : 68'(v);
	endfunction

	// overshoot test on one axis
	function automatic bit near_target(longint f, longint d, logic [67:0] thr);
		if (f == 0 || d == 0 || ((f < 0) != (d < 0)))
			return 1;
		return mag68(f) * mag68(d) <= thr;
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sh7FFFFFFF) return 64'sh7FFFFFFF;
		if (v < -64'sh80000000) return -64'sh80000000;
		return v;
	endfunction

	function automatic logic [63:0] predict_step(logic [159:0] mv, logic [15:0] eps);
		longint      px, py, tx, ty, dx, dy, vx, vy, sp, res_x, res_y;
		logic [67:0] mx, my, sum, root, c, thr, q;
		px = longint'($signed(mv[31:0]));
		py = longint'($signed(mv[63:32]));
		tx = longint'($signed(mv[95:64]));
		ty = longint'($signed(mv[127:96]));
		sp = longint'(mv[158:128]);
		dx = tx - px;
		dy = ty - py;
		vx = dx;
		vy = dy;
		mx = mag68(dx);
		my = mag68(dy);
		sum = mx * mx + my * my;
		root = 0;
		for (int b = 33; b >= 0; b--) begin
			c = root | (68'd1 << b);
			if (c * c <= sum)
				root = c;
		end
		thr = ((68'(eps) + 68'd1) << stv_pkg::FRAC_BITS) - 68'd1;
		if (root > 68'(eps)) begin
			q = (mx * 68'(sp)) / root;
			vx = dx < 0 ? -longint'(q[62:0]) : longint'(q[62:0]);
			q = (my * 68'(sp)) / root;
			vy = dy < 0 ? -longint'(q[62:0]) : longint'(q[62:0]);
		end
		if (near_target(dx - vx, dx, thr) && near_target(dy - vy, dy, thr)) begin
			vx = dx;
			vy = dy;
		end
		res_x = clamp32(vx);
		res_y = clamp32(vy);
		return {res_y[31:0], res_x[31:0]};
	endfunction

	function automatic logic [159:0] pack_move(logic [31:0] px, logic [31:0] py,
			logic [31:0] tx, logic [31:0] ty, logic [30:0] sp);
		return {1'b0, sp, ty, tx, py, px};
	endfunction

	function automatic logic [159:0] random_move();
		logic [31:0] px, py, tx, ty;
		logic [30:0] sp;
		int          k, sh;
		px = $urandom;
		py = $urandom;
		sp = 31'($urandom);
		k = $urandom_range(0, 3);
		if (k == 0) begin
			tx = $urandom;
			ty = $urandom;
		end else begin
			// target close to position: short vectors and overshoot
			sh = $urandom_range(0, 31);
			tx = px + ($signed($urandom) >>> sh);
			ty = py + ($signed($urandom) >>> sh);
			sp = sp >> $urandom_range(0, 30);
		end
		return pack_move(px, py, tx, ty, sp);
	endfunction

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// driver
	always @(negedge clk) begin
		if (arst_n && (!s_axis_tvalid || in_xfer)) begin
			if (pending_moves.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
				s_axis_tdata <= pending_moves.pop_front();
				s_axis_tvalid <= 1;
			end else begin
				s_axis_tvalid <= 0;
			end
		end
	end

	// receiver with an optional long hold-off
	always @(negedge clk) begin
		if (hold_go && !hold_done && hold_cnt == 0) begin
			hold_cnt <= 500;
			hold_done <= 1;
			m_axis_tready <= 0;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			m_axis_tready <= 0;
		end else begin
			m_axis_tready <= $urandom_range(0, 99) >= stall_pct;
		end
	end

	// monitor
	always @(posedge clk) begin
		logic [63:0] want;
		in_xfer <= s_axis_tvalid && s_axis_tready;
		if (arst_n && s_axis_tvalid && s_axis_tready)
			expected_steps.push_back(predict_step(s_axis_tdata, epsilon));
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_steps.size() == 0) begin
				$error("unexpected result transfer %h", m_axis_tdata);
				errors++;
			end else begin
				want = expected_steps.pop_front();
				if (want[31:0] !== m_axis_tdata[31:0]) begin
					$error("step_x expected %h got %h", want[31:0], m_axis_tdata[31:0]);
					errors++;
				end
				if (want[63:32] !== m_axis_tdata[63:32]) begin
					$error("step_y expected %h got %h", want[63:32], m_axis_tdata[63:32]);
					errors++;
				end
			end
		end
	end

	task automatic wait_drained();
		while (pending_moves.size() > 0 || s_axis_tvalid || expected_steps.size() > 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic set_epsilon(logic [15:0] v);
		@(negedge clk);
		cfg_we <= 1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 0;
		epsilon = v;
	endtask

	initial begin
		logic [15:0] eps_list[8];
		int          idle_list[8], stall_list[8];
		errors = 0;
		cycles = 0;
		hold_cnt = 0;
		hold_go = 0;
		hold_done = 0;
		in_xfer = 0;
		cfg_we = 0;
		cfg_wdata = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = 0;
		m_axis_tready = 0;
		idle_pct = 0;
		stall_pct = 0;
		epsilon = 1;
		arst_n = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed part at reset epsilon
		pending_moves.push_back(pack_move(0, 0, 0, 0, 31'd0));
		pending_moves.push_back(pack_move(0, 0, 1, 0, 31'h7FFFFFFF));
		pending_moves.push_back(pack_move(32'h80000000, 32'h80000000,
			32'h7FFFFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF));
		pending_moves.push_back(pack_move(32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h80000000, 32'h80000000, 31'h7FFFFFFF));
		pending_moves.push_back(pack_move(32'h80000000, 0, 32'h7FFFFFFF, 0, 31'd0));
		pending_moves.push_back(pack_move(0, 32'h7FFFFFFF, 0, 32'h80000000, 31'd1));
		pending_moves.push_back(pack_move(0, 0, 32'h00030000, 32'h00040000, 31'h00010000));
		pending_moves.push_back(pack_move(0, 0, 32'h00030000, 32'h00040000, 31'h00050000));
		pending_moves.push_back(pack_move(0, 0, 32'h00030000, 32'h00040000, 31'h00060000));
		pending_moves.push_back(pack_move(5, 5, 4, 6, 31'h7FFFFFFF));
		pending_moves.push_back(pack_move(32'hFFFF0000, 32'h10000, 32'h10000,
			32'hFFFF0000, 31'h00008000));
		pending_moves.push_back(pack_move(32'h12345678, 32'h9ABCDEF0, 32'h12345679,
			32'h9ABCDEF0, 31'h00000001));
		wait_drained();

		eps_list = '{16'd0, 16'd65535, 16'd1, 16'd300, 16'd0, 16'd65535, 16'd17, 16'd1};
		idle_list = '{0, 66, 0, 6, 0, 66, 0, 6};
		stall_list = '{0, 0, 66, 6, 0, 0, 66, 6};
		for (int p = 0; p < 8; p++) begin
			if (p == 3)
				eps_list[p] = 16'($urandom);
			set_epsilon(eps_list[p]);
			idle_pct = idle_list[p];
			stall_pct = stall_list[p];
			if (p == 4) begin
				pending_moves.push_back(pack_move(0, 0, 0, 32'h00000002, 31'h7FFFFFFF));
				pending_moves.push_back(pack_move(0, 0, 32'hFFFFFFFF, 0, 31'h7FFFFFFF));
			end
			for (int i = 0; i < 242; i++)
				pending_moves.push_back(random_move());
			if (p == 4)
				hold_go = 1;
			wait_drained();
		end

		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
